// File: hw/rtl/cpc_pkg.sv
`timescale 1ns / 1ps

package cpc_pkg;

    localparam int CURVE_W = 12;
    localparam int COUNT_W = 13;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1FFF;

    typedef enum logic [2:0] {
        SEL_A_RAW = 3'd0,
        SEL_B_RAW = 3'd1,
        SEL_AA    = 3'd2,
        SEL_A3    = 3'd3,
        SEL_BB    = 3'd4,
        SEL_DISC  = 3'd5,
        SEL_SIX   = 3'd6
    } t_red_sel;

    typedef enum logic [2:0] {
        DST_NONE = 3'd0,
        DST_A    = 3'd1,
        DST_B    = 3'd2,
        DST_T    = 3'd3,
        DST_U    = 3'd4,
        DST_SIX  = 3'd5
    } t_red_dst;

    typedef struct packed {
        logic     load;
        logic     mark_sing;
        logic     red_start;
        t_red_sel red_sel;
        t_red_dst red_dst;
        logic     init_scan;
        logic     clr_step;
        logic     fill_step;
        logic     scan_step;
        logic     emit;
    } t_cmd;

    typedef struct packed {
        logic p_small;
        logic red_busy;
        logic red_zero;
        logic idx_at_end;
        logic idx_at_half;
        logic out_full;
    } t_status;

endpackage

// File: hw/rtl/cpc_if.sv
`timescale 1ns / 1ps

interface cpc_in_if;
    import cpc_pkg::*;

    logic               valid;
    logic               ready;
    logic [CURVE_W-1:0] curve_a;
    logic [CURVE_W-1:0] curve_b;
    logic [CURVE_W-1:0] field_prime;

    modport source (output valid, output curve_a, output curve_b, output field_prime,
                    input ready);
    modport sink (input valid, input curve_a, input curve_b, input field_prime,
                  output ready);
endinterface

interface cpc_out_if;
    import cpc_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] point_count;
    logic               singular;

    modport source (output valid, output point_count, output singular, input ready);
    modport sink (input valid, input point_count, input singular, output ready);
endinterface

// File: hw/rtl/cpc_modred.sv
`timescale 1ns / 1ps

module cpc_modred #(
    parameter int W  = 12,
    parameter int RW = 29
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [RW-1:0] i_dividend,
    input  logic [W-1:0]  i_modulus,
    output logic          o_busy,
    output logic [W-1:0]  o_rem
);
    localparam int CNT_W = $clog2(RW + 1);

    logic [RW-1:0]    r_div;
    logic [W-1:0]     r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [W:0]       n_trial;
    logic [W-1:0]     n_rem;

    always_comb begin
        n_trial = {r_rem, r_div[RW-1]};
        if (n_trial >= {1'b0, i_modulus}) begin
            n_trial = n_trial - {1'b0, i_modulus};
        end
        n_rem = n_trial[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(RW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_div <= {r_div[RW-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_rem  = r_rem;

endmodule

// File: hw/rtl/cpc_datapath.sv
`timescale 1ns / 1ps

module cpc_datapath #(
    parameter int W = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  cpc_pkg::t_cmd           i_cmd,
    output cpc_pkg::t_status        o_status,
    input  logic [cpc_pkg::CURVE_W-1:0] i_curve_a,
    input  logic [cpc_pkg::CURVE_W-1:0] i_curve_b,
    input  logic [cpc_pkg::CURVE_W-1:0] i_field_prime,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic [cpc_pkg::COUNT_W-1:0] o_point_count,
    output logic                    o_singular
);
    import cpc_pkg::*;

    localparam int RW    = (2 * W + 5 > CURVE_W) ? 2 * W + 5 : CURVE_W;
    localparam int DEPTH = 1 << W;
    localparam int CW    = W + 2;
    localparam int XW    = (CW > COUNT_W) ? CW : COUNT_W;

    function automatic logic [W-1:0] mod_add(input logic [W-1:0] x, input logic [W-1:0] y,
                                             input logic [W-1:0] m);
        logic [W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[W-1:0];
    endfunction

    logic [CURVE_W-1:0] r_a_raw;
    logic [CURVE_W-1:0] r_b_raw;
    logic [W-1:0]       r_p;
    logic [W-1:0]       r_a;
    logic [W-1:0]       r_b;
    logic [W-1:0]       r_t;
    logic [W-1:0]       r_u;
    logic [W-1:0]       r_six;
    logic               r_sing;
    logic [W-1:0]       r_idx;
    logic [W-1:0]       r_sq;
    logic [W-1:0]       r_odd;
    logic               r_zroot;
    logic [W-1:0]       r_v;
    logic [W-1:0]       r_d1;
    logic [W-1:0]       r_d2;
    logic               r_chk;
    logic               r_mark;
    logic [W-1:0]       r_vq;
    logic [CW-1:0]      r_count;
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_sing;
    logic               r_residue_marks [DEPTH];

    logic [W-1:0]       mul_x;
    logic [W-1:0]       mul_y;
    logic [2*W-1:0]     product;
    logic [RW-1:0]      dividend;
    logic               red_busy;
    logic [W-1:0]       red_rem;
    logic [W-1:0]       two_mod;
    logic               mem_we;
    logic [W-1:0]       mem_wa;
    logic               mem_wd;
    logic               idx_at_end;
    logic               idx_at_half;
    logic [CW-1:0]      total;
    logic [XW-1:0]      total_x;
    logic [COUNT_W-1:0] sat_count;

    always_comb begin
        mul_x = r_a;
        mul_y = r_a;
        unique case (i_cmd.red_sel)
            SEL_A3: begin
                mul_x = r_t;
                mul_y = r_a;
            end
            SEL_BB: begin
                mul_x = r_b;
                mul_y = r_b;
            end
            default: begin
                mul_x = r_a;
                mul_y = r_a;
            end
        endcase
    end

    assign product = mul_x * mul_y;

    always_comb begin
        unique case (i_cmd.red_sel)
            SEL_A_RAW: dividend = RW'(r_a_raw);
            SEL_B_RAW: dividend = RW'(r_b_raw);
            SEL_AA, SEL_A3, SEL_BB: dividend = RW'(product);
            SEL_DISC:  dividend = (RW'(r_t) << 2) + (RW'(r_u) << 4) + (RW'(r_u) << 3)
                                + (RW'(r_u) << 1) + RW'(r_u);
            SEL_SIX:   dividend = RW'(6);
            default:   dividend = '0;
        endcase
    end

    cpc_modred #(
        .W  (W),
        .RW (RW)
    ) u_modred (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.red_start),
        .i_dividend (dividend),
        .i_modulus  (r_p),
        .o_busy     (red_busy),
        .o_rem      (red_rem)
    );

    assign two_mod     = (r_p == W'(2)) ? '0 : W'(2);
    assign idx_at_end  = (r_idx == r_p - W'(1));
    assign idx_at_half = (r_idx == (r_p >> 1));

    assign mem_we = i_cmd.clr_step | i_cmd.fill_step;
    assign mem_wa = i_cmd.fill_step ? r_sq : r_idx;
    assign mem_wd = i_cmd.fill_step;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_residue_marks[mem_wa] <= mem_wd;
        end
        r_mark <= r_residue_marks[r_v];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a_raw <= i_curve_a;
            r_b_raw <= i_curve_b;
            r_p     <= W'(i_field_prime);
            r_sing  <= 1'b0;
        end else if (i_cmd.mark_sing) begin
            r_sing <= 1'b1;
        end

        case (i_cmd.red_dst)
            DST_A:   r_a   <= red_rem;
            DST_B:   r_b   <= red_rem;
            DST_T:   r_t   <= red_rem;
            DST_U:   r_u   <= red_rem;
            DST_SIX: r_six <= red_rem;
            default: ;
        endcase

        if (i_cmd.init_scan) begin
            r_sq    <= '0;
            r_odd   <= W'(1);
            r_zroot <= 1'b0;
            r_v     <= r_b;
            r_d1    <= mod_add(r_a, W'(1), r_p);
            r_d2    <= r_six;
            r_count <= '0;
        end else begin
            if (i_cmd.fill_step) begin
                r_sq  <= mod_add(r_sq, r_odd, r_p);
                r_odd <= mod_add(r_odd, two_mod, r_p);
                if (r_sq == '0 && r_idx != '0) begin
                    r_zroot <= 1'b1;
                end
            end
            if (i_cmd.scan_step) begin
                r_v  <= mod_add(r_v, r_d1, r_p);
                r_d1 <= mod_add(r_d1, r_d2, r_p);
                r_d2 <= mod_add(r_d2, r_six, r_p);
            end
            if (r_chk && r_mark) begin
                r_count <= r_count + ((r_vq != '0 || r_zroot) ? CW'(2) : CW'(1));
            end
        end
        r_vq <= r_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_chk <= 1'b0;
        end else begin
            r_chk <= i_cmd.scan_step;
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if ((i_cmd.clr_step && idx_at_end) || (i_cmd.fill_step && idx_at_half)
                         || (i_cmd.scan_step && idx_at_end)) begin
                r_idx <= '0;
            end else if (i_cmd.clr_step || i_cmd.fill_step || i_cmd.scan_step) begin
                r_idx <= r_idx + W'(1);
            end
        end
    end

    always_comb begin
        total     = r_count + CW'(1);
        total_x   = XW'(total);
        sat_count = (total_x > XW'(COUNT_MAX)) ? COUNT_MAX : total_x[COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_count <= r_sing ? '0 : sat_count;
            r_out_sing  <= r_sing;
        end
    end

    always_comb begin
        o_status.p_small     = (r_p[W-1:1] == '0);
        o_status.red_busy    = red_busy;
        o_status.red_zero    = (red_rem == '0);
        o_status.idx_at_end  = idx_at_end;
        o_status.idx_at_half = idx_at_half;
        o_status.out_full    = r_out_valid;
    end

    assign o_out_valid   = r_out_valid;
    assign o_point_count = r_out_count;
    assign o_singular    = r_out_sing;

endmodule

// File: hw/rtl/cpc_ctrl.sv
`timescale 1ns / 1ps

module cpc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    input  cpc_pkg::t_status i_status,
    output cpc_pkg::t_cmd    o_cmd
);
    import cpc_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE     = 14'h0001,
        S_CHK_P    = 14'h0002,
        S_RED_A    = 14'h0004,
        S_RED_B    = 14'h0008,
        S_RED_AA   = 14'h0010,
        S_RED_A3   = 14'h0020,
        S_RED_BB   = 14'h0040,
        S_RED_DISC = 14'h0080,
        S_RED_SIX  = 14'h0100,
        S_CLEAR    = 14'h0200,
        S_FILL     = 14'h0400,
        S_SCAN     = 14'h0800,
        S_DRAIN    = 14'h1000,
        S_EMIT     = 14'h2000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_first;
    logic   n_first;
    logic   red_done;

    assign red_done = !r_first && !i_status.red_busy;

    always_comb begin
        n_state         = r_state;
        o_in_ready      = 1'b0;
        o_cmd           = '0;
        o_cmd.red_sel   = SEL_A_RAW;
        o_cmd.red_dst   = DST_NONE;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHK_P;
                end
            end
            S_CHK_P: begin
                if (i_status.p_small) begin
                    o_cmd.mark_sing = 1'b1;
                    n_state         = S_EMIT;
                end else begin
                    n_state = S_RED_A;
                end
            end
            S_RED_A: begin
                o_cmd.red_sel   = SEL_A_RAW;
                o_cmd.red_start = r_first;
                if (red_done) begin
                    o_cmd.red_dst = DST_A;
                    n_state       = S_RED_B;
                end
            end
            S_RED_B: begin
                o_cmd.red_sel   = SEL_B_RAW;
                o_cmd.red_start = r_first;
                if (red_done) begin
                    o_cmd.red_dst = DST_B;
                    n_state       = S_RED_AA;
                end
            end
            S_RED_AA: begin
                o_cmd.red_sel   = SEL_AA;
                o_cmd.red_start = r_first;
                if (red_done) begin
                    o_cmd.red_dst = DST_T;
                    n_state       = S_RED_A3;
                end
            end
            S_RED_A3: begin
                o_cmd.red_sel   = SEL_A3;
                o_cmd.red_start = r_first;
                if (red_done) begin
                    o_cmd.red_dst = DST_T;
                    n_state       = S_RED_BB;
                end
            end
            S_RED_BB: begin
                o_cmd.red_sel   = SEL_BB;
                o_cmd.red_start = r_first;
                if (red_done) begin
                    o_cmd.red_dst = DST_U;
                    n_state       = S_RED_DISC;
                end
            end
            S_RED_DISC: begin
                o_cmd.red_sel   = SEL_DISC;
                o_cmd.red_start = r_first;
                if (red_done) begin
                    if (i_status.red_zero) begin
                        o_cmd.mark_sing = 1'b1;
                        n_state         = S_EMIT;
                    end else begin
                        n_state = S_RED_SIX;
                    end
                end
            end
            S_RED_SIX: begin
                o_cmd.red_sel   = SEL_SIX;
                o_cmd.red_start = r_first;
                if (red_done) begin
                    o_cmd.red_dst = DST_SIX;
                    n_state       = S_CLEAR;
                end
            end
            S_CLEAR: begin
                o_cmd.init_scan = r_first;
                o_cmd.clr_step  = 1'b1;
                if (i_status.idx_at_end) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_status.idx_at_half) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.idx_at_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_status.out_full || i_out_ready) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_first = (n_state != r_state);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_first <= n_first;
        end
    end

endmodule

// File: hw/rtl/curve_point_counter_top.sv
// Curve point counter.
// Each request on i_in carries coefficients curve_a, curve_b and the modulus
// field_prime; the block answers with one result on o_out giving the number of
// points of y^2 = x^3 + a*x + b modulo p, including infinity, or singular = 1
// with point_count = 0 when the discriminant vanishes or p is below two.
// A request is taken only while the controller is idle, one at a time.
// A modulus below two goes from the check state straight to the emit state.
// Otherwise seven modular reductions run on a shared bit-serial reducer of
// RW = max(2*PRIME_BITS + 5, 12) steps each; a singular curve is answered
// there. A regular curve then clears the residue map, marks the squares and
// scans every x with a single read port of the map, then drains the last
// lookup in a drain state before the result is emitted.
// The result sits in an output register: the next request is taken while it
// waits, and a stalled receiver only holds the following result back.
// Reset is synchronous and active low; it empties the output register and
// returns the controller to idle. The residue map needs no clearing at reset.
`timescale 1ns / 1ps

module curve_point_counter_top #(
    parameter int PRIME_BITS = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cpc_in_if.sink     i_in,
    cpc_out_if.source  o_out
);
    import cpc_pkg::*;

    t_cmd    cmd;
    t_status status;

    cpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    cpc_datapath #(
        .W (PRIME_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_curve_a     (i_in.curve_a),
        .i_curve_b     (i_in.curve_b),
        .i_field_prime (i_in.field_prime),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_point_count (o_out.point_count),
        .o_singular    (o_out.singular)
    );

endmodule

// File: hw/rtl/cpc_checker.sv
`timescale 1ns / 1ps

module cpc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [cpc_pkg::COUNT_W-1:0] i_point_count,
    input logic                        i_singular
);
    import cpc_pkg::*;

    // A result that is not taken stays offered unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_point_count) && $stable(i_singular)))
        else $error("stalled result changed");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request taken while another is in progress");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_singular) |-> (i_point_count == '0))
        else $error("singular result with nonzero count");

    a_regular_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_singular) |-> (i_point_count != '0))
        else $error("regular result without the point at infinity");

endmodule

bind curve_point_counter_top cpc_checker u_cpc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_point_count (o_out.point_count),
    .i_singular    (o_out.singular)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cpc_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int RESET_LEN   = 11;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_WAIT  = 300;
    localparam int MAP_SIZE    = 1 << CURVE_W;

    typedef struct {
        logic [CURVE_W-1:0] a;
        logic [CURVE_W-1:0] b;
        logic [CURVE_W-1:0] p;
        logic [COUNT_W-1:0] point_count;
        logic               singular;
    } t_curve_count;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cpc_in_if  curve_req ();
    cpc_out_if count_res ();

    curve_point_counter_top #(
        .PRIME_BITS(CURVE_W)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (curve_req),
        .o_out  (count_res)
    );

    t_curve_count pending_counts[$];
    bit           square_marks[MAP_SIZE];
    bit           zero_root_seen;
    int           sender_idle_pct;
    int           receiver_stall_pct;
    int           error_count;
    int           cycle_count;

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL curve_point_counter_top");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        count_res.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    function automatic t_curve_count count_curve_points(input logic [CURVE_W-1:0] a_in,
                                                        input logic [CURVE_W-1:0] b_in,
                                                        input logic [CURVE_W-1:0] p_in);
        int unsigned  p, a, b, a3, b2, disc, half, r, v, cnt;
        t_curve_count res;
        res.a           = a_in;
        res.b           = b_in;
        res.p           = p_in;
        res.point_count = '0;
        res.singular    = 1'b1;
        p = 32'(p_in);
        if (p < 2) begin
            return res;
        end
        a    = 32'(a_in) % p;
        b    = 32'(b_in) % p;
        a3   = (((a * a) % p) * a) % p;
        b2   = (b * b) % p;
        disc = (4 * a3 + 27 * b2) % p;
        if (disc == 0) begin
            return res;
        end
        for (int unsigned i = 0; i < p; i++) begin
            square_marks[i] = 1'b0;
        end
        zero_root_seen = 1'b0;
        half = p >> 1;
        for (int unsigned i = 0; i <= half; i++) begin
            r = (i * i) % p;
            square_marks[r] = 1'b1;
            if (r == 0 && i != 0) begin
                zero_root_seen = 1'b1;
            end
        end
        cnt = 0;
        for (int unsigned x = 0; x < p; x++) begin
            v = ((((x * x) % p) * x) % p + (a * x) % p + b) % p;
            if (square_marks[v]) begin
                cnt++;
                if (v != 0 || zero_root_seen) begin
                    cnt++;
                end
            end
        end
        cnt++;
        if (cnt > COUNT_MAX) begin
            cnt = COUNT_MAX;
        end
        res.point_count = cnt[COUNT_W-1:0];
        res.singular    = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input t_curve_count exp_res,
                                   input int exp_val, input int got_val);
        $display("mismatch %s: a=%0d b=%0d p=%0d expected %0d got %0d at cycle %0d",
                 what, exp_res.a, exp_res.b, exp_res.p, exp_val, got_val, cycle_count);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_curve_count exp_res;
        if (i_rst_n && count_res.valid && count_res.ready) begin
            if (pending_counts.size() == 0) begin
                exp_res = '{default: '0};
                report_mismatch("result without request", exp_res, 0,
                                int'(count_res.point_count));
            end else begin
                exp_res = pending_counts.pop_front();
                if (count_res.point_count !== exp_res.point_count) begin
                    report_mismatch("point_count", exp_res, int'(exp_res.point_count),
                                    int'(count_res.point_count));
                end
                if (count_res.singular !== exp_res.singular) begin
                    report_mismatch("singular", exp_res, int'(exp_res.singular),
                                    int'(count_res.singular));
                end
            end
        end
    end

    task automatic send_curve(input int a, input int b, input int p);
        while ($urandom_range(99) < sender_idle_pct) begin
            curve_req.valid <= 1'b0;
            @(negedge i_clk);
        end
        curve_req.valid       <= 1'b1;
        curve_req.curve_a     <= a[CURVE_W-1:0];
        curve_req.curve_b     <= b[CURVE_W-1:0];
        curve_req.field_prime <= p[CURVE_W-1:0];
        do begin
            @(posedge i_clk);
        end while (!curve_req.ready);
        pending_counts = {pending_counts,
                          count_curve_points(a[CURVE_W-1:0], b[CURVE_W-1:0],
                                             p[CURVE_W-1:0])};
        @(negedge i_clk);
    endtask

    task automatic wait_for_drain();
        curve_req.valid <= 1'b0;
        while (pending_counts.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic run_random_curves(input int n_items, input int idle_pct,
                                     input int stall_pct);
        int kind;
        int p;
        int a;
        int b;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int n = 0; n < n_items; n++) begin
            kind = $urandom_range(99);
            if (n == 0) begin
                p = $urandom_range(4095, 2);
            end else if (kind < 5) begin
                p = $urandom_range(1, 0);
            end else begin
                p = $urandom_range(255, 2);
            end
            a = $urandom_range(4095);
            b = $urandom_range(4095);
            if (kind >= 5 && kind < 15 && p >= 3) begin
                a = p - 3;
                b = 2 + p * $urandom_range(3);
            end
            send_curve(a, b, p);
        end
    endtask

    task automatic test_small_and_degenerate_moduli();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_curve(5, 7, 0);
        send_curve(4095, 4095, 1);
        send_curve(1, 1, 2);
        send_curve(0, 0, 2);
        send_curve(1, 0, 3);
        send_curve(0, 0, 3);
        send_curve(2, 3, 5);
        send_curve(4, 2, 7);
        send_curve(1, 1, 4);
        send_curve(2, 5, 9);
        send_curve(3, 1, 8);
        send_curve(4095, 4095, 11);
        send_curve(0, 0, 13);
        send_curve(0, 5, 17);
        send_curve(7, 0, 23);
        send_curve(98, 2, 101);
        send_curve(499, 253, 251);
    endtask

    task automatic test_idle_drain_and_resume();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_curve(2, 3, 5);
        send_curve(4, 6, 19);
        wait_for_drain();
        @(negedge i_clk);
        send_curve(1, 2, 29);
    endtask

    task automatic test_large_moduli();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_curve(4095, 4095, 4093);
        send_curve(4095, 1, 4095);
        send_curve(2, 3, 4094);
        send_curve(0, 1, 2048);
    endtask

    task automatic test_random_back_to_back();
        run_random_curves(20, 0, 0);
    endtask

    task automatic test_random_sender_idle();
        run_random_curves(20, 79, 0);
    endtask

    task automatic test_random_receiver_stall();
        run_random_curves(20, 0, 79);
    endtask

    task automatic test_random_both_idle();
        run_random_curves(20, 10, 10);
    endtask

    initial begin
        error_count           = 0;
        cycle_count           = 0;
        sender_idle_pct       = 0;
        receiver_stall_pct    = 0;
        i_rst_n               = 1'b0;
        curve_req.valid       = 1'b0;
        curve_req.curve_a     = '0;
        curve_req.curve_b     = '0;
        curve_req.field_prime = '0;
        count_res.ready       = 1'b0;
        repeat (RESET_LEN) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_small_and_degenerate_moduli();
        test_idle_drain_and_resume();
        test_large_moduli();
        test_random_back_to_back();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();

        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        wait_for_drain();
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (error_count == 0) begin
            $display("PASS curve_point_counter_top");
        end else begin
            $display("FAIL curve_point_counter_top");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/cpc_pkg.sv
hw/rtl/cpc_if.sv
hw/rtl/cpc_modred.sv
hw/rtl/cpc_datapath.sv
hw/rtl/cpc_ctrl.sv
hw/rtl/curve_point_counter_top.sv
hw/rtl/cpc_checker.sv
tb/testbench.sv
